### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. Define NO_ASSERTIONS to
// compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### hw/rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Sizes, codes and shared types of the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int DEPTH      = 1024;
   localparam int WORD_WIDTH = 32;

   // Fixed widths of the item fields.
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 11;
   localparam int STATUS_W = 3;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WIDE_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam int REQ_DATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((STATUS_W + 2 * POS_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_INSERT     = 3'd4,
      CMD_MODIFY     = 3'd5,
      CMD_FIND       = 3'd6,
      CMD_CLEAR      = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_BAD_POS   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_SATURATED = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_SEARCH,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic decode;
      logic setup_up;
      logic setup_down;
      logic setup_find;
      logic step_up;
      logic step_down;
      logic step_find;
      logic write_word;
      logic write_modify;
      logic load_rsp;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    ins_ok;
      logic    mod_ok;
      logic    busy;
      logic    hit;
      logic    rsp_free;
   } stat_type;

endpackage

### hw/rtl/pal_ram.sv
// ----------------------------------------------------------------------------
// pal_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pal_datapath.sv
// ----------------------------------------------------------------------------
// pal_datapath
// Length, walk pointers, entry RAM, match compare and response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pal_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pal_pkg::ctrl_type             ctl,
   output pal_pkg::stat_type             stat,
   input  logic [pal_pkg::CMD_W-1:0]     req_command,
   input  logic [pal_pkg::VALUE_W-1:0]   req_value,
   input  logic [pal_pkg::POS_W-1:0]     req_position,
   input  logic                          rsp_tready,
   output logic                          rsp_valid,
   output pal_pkg::status_type           rsp_status,
   output logic [pal_pkg::POS_W-1:0]     rsp_found_position,
   output logic [pal_pkg::POS_W-1:0]     rsp_length
);

   // Held item.
   pal_pkg::cmd_type                  cmd_ff;
   logic [pal_pkg::VALUE_W-1:0]       value_ff;
   logic [pal_pkg::POS_W-1:0]         pos_ff;
   logic [pal_pkg::WORD_WIDTH-1:0]    word_ff;

   logic [pal_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [pal_pkg::ADDR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [pal_pkg::ADDR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [pal_pkg::ADDR_W-1:0]        last_ff, last_in;
   logic                              rd_more_ff, rd_more_in;
   logic                              pend_ff, pend_in;
   pal_pkg::status_type               status_ff, status_in;
   logic [pal_pkg::CNT_W-1:0]         found_ff, found_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   pal_pkg::status_type               rsp_status_ff;
   logic [pal_pkg::POS_W-1:0]         rsp_found_ff;
   logic [pal_pkg::POS_W-1:0]         rsp_length_ff;

   // Decode terms.
   logic                              full, empty, ins_ok, mod_ok;
   logic [pal_pkg::WIDE_W-1:0]        pos_x, cnt_x;
   logic [pal_pkg::ADDR_W-1:0]        pos_addr, ins_idx;
   logic                              pop_neg, pop_sat;
   logic [pal_pkg::CNT_W-1:0]         pop_n;
   pal_pkg::status_type               dec_status;
   logic [pal_pkg::CNT_W-1:0]         dec_count;

   // RAM ports.
   logic                              wr_en, rd_en;
   logic [pal_pkg::ADDR_W-1:0]        wr_addr;
   logic [pal_pkg::WORD_WIDTH-1:0]    wr_data, rd_data;
   logic                              hit, step_any;

   // Words are the 32-bit value sign-extended, then cut to the word width.
   function automatic logic [pal_pkg::WORD_WIDTH-1:0] word_of(
      input logic [pal_pkg::VALUE_W-1:0] v);
      logic signed [63:0] ext;
      ext = 64'(signed'(v));
      return ext[pal_pkg::WORD_WIDTH-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff   <= pal_pkg::cmd_type'(req_command);
         value_ff <= req_value;
         pos_ff   <= req_position;
         word_ff  <= word_of(req_value);
      end
   end

   always_comb begin
      full     = (count_ff == pal_pkg::CNT_W'(pal_pkg::DEPTH));
      empty    = (count_ff == '0);
      pos_x    = pal_pkg::WIDE_W'(pos_ff);
      cnt_x    = pal_pkg::WIDE_W'(count_ff);
      ins_ok   = (pos_ff != '0) && (pos_x <= cnt_x + pal_pkg::WIDE_W'(1));
      mod_ok   = (pos_ff != '0) && (pos_x <= cnt_x);
      pos_addr = pal_pkg::ADDR_W'(pos_x - pal_pkg::WIDE_W'(1));
      pop_neg  = value_ff[pal_pkg::VALUE_W-1];
      pop_sat  = !pop_neg && (value_ff > pal_pkg::VALUE_W'(count_ff));
      if (pop_neg) begin
         pop_n = '0;
      end else if (pop_sat) begin
         pop_n = count_ff;
      end else begin
         pop_n = pal_pkg::CNT_W'(value_ff);
      end
      case (cmd_ff)
         pal_pkg::CMD_PUSH_BACK:  ins_idx = pal_pkg::ADDR_W'(count_ff);
         pal_pkg::CMD_PUSH_FRONT: ins_idx = '0;
         default:                 ins_idx = pos_addr;
      endcase
   end

   // Result and new length of the held command.
   always_comb begin
      dec_status = pal_pkg::ST_OK;
      dec_count  = count_ff;
      case (cmd_ff)
         pal_pkg::CMD_PUSH_BACK, pal_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
               dec_status = pal_pkg::ST_FULL;
            end else begin
               dec_count = count_ff + pal_pkg::CNT_W'(1);
            end
         end
         pal_pkg::CMD_POP_BACK, pal_pkg::CMD_POP_FRONT: begin
            if (empty) begin
               dec_status = pal_pkg::ST_EMPTY;
            end else begin
               dec_status = pop_sat ? pal_pkg::ST_SATURATED : pal_pkg::ST_OK;
               dec_count  = count_ff - pop_n;
            end
         end
         pal_pkg::CMD_INSERT: begin
            if (full) begin
               dec_status = pal_pkg::ST_FULL;
            end else if (!ins_ok) begin
               dec_status = pal_pkg::ST_BAD_POS;
            end else begin
               dec_count = count_ff + pal_pkg::CNT_W'(1);
            end
         end
         pal_pkg::CMD_MODIFY: begin
            dec_status = mod_ok ? pal_pkg::ST_OK : pal_pkg::ST_BAD_POS;
         end
         pal_pkg::CMD_FIND: begin
            dec_status = pal_pkg::ST_NOT_FOUND;
         end
         pal_pkg::CMD_CLEAR: begin
            dec_count = '0;
         end
         default: begin
            dec_status = pal_pkg::ST_OK;
         end
      endcase
   end

   assign hit      = pend_ff && (rd_data == word_ff);
   assign step_any = ctl.step_up || ctl.step_down || ctl.step_find;

   always_comb begin
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      last_in    = last_ff;
      rd_more_in = rd_more_ff;
      pend_in    = pend_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      if (ctl.decode) begin
         count_in  = dec_count;
         status_in = dec_status;
         found_in  = '0;
      end
      // Shift up: read from length-1 down to the insert slot, write one higher.
      if (ctl.setup_up) begin
         rd_ptr_in  = pal_pkg::ADDR_W'(count_ff - pal_pkg::CNT_W'(1));
         wr_ptr_in  = pal_pkg::ADDR_W'(count_ff);
         last_in    = ins_idx;
         rd_more_in = (count_ff > pal_pkg::CNT_W'(ins_idx));
         pend_in    = 1'b0;
      end
      // Shift down: read from N up to length-1, write from slot zero.
      if (ctl.setup_down) begin
         rd_ptr_in  = pal_pkg::ADDR_W'(pop_n);
         wr_ptr_in  = '0;
         last_in    = pal_pkg::ADDR_W'(count_ff - pal_pkg::CNT_W'(1));
         rd_more_in = (pop_n != '0) && (pop_n < count_ff);
         pend_in    = 1'b0;
      end
      if (ctl.setup_find) begin
         rd_ptr_in  = '0;
         wr_ptr_in  = '0;
         last_in    = pal_pkg::ADDR_W'(count_ff - pal_pkg::CNT_W'(1));
         rd_more_in = !empty;
         pend_in    = 1'b0;
      end
      if (step_any) begin
         rd_more_in = rd_more_ff && (rd_ptr_ff != last_ff);
         pend_in    = rd_more_ff;
         if (ctl.step_up) begin
            rd_ptr_in = rd_ptr_ff - pal_pkg::ADDR_W'(1);
            if (pend_ff) begin
               wr_ptr_in = wr_ptr_ff - pal_pkg::ADDR_W'(1);
            end
         end else begin
            rd_ptr_in = rd_ptr_ff + pal_pkg::ADDR_W'(1);
            if (pend_ff) begin
               wr_ptr_in = wr_ptr_ff + pal_pkg::ADDR_W'(1);
            end
         end
      end
      if (ctl.step_find && hit) begin
         found_in  = pal_pkg::CNT_W'(wr_ptr_ff) + pal_pkg::CNT_W'(1);
         status_in = pal_pkg::ST_OK;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_ptr_ff;
      wr_data = rd_data;
      if ((ctl.step_up || ctl.step_down) && pend_ff) begin
         wr_en = 1'b1;
      end else if (ctl.write_word) begin
         wr_en   = 1'b1;
         wr_addr = last_ff;
         wr_data = word_ff;
      end else if (ctl.write_modify) begin
         wr_en   = 1'b1;
         wr_addr = pos_addr;
         wr_data = word_ff;
      end
   end

   assign rd_en = step_any && rd_more_ff;

   pal_ram #(
      .WIDTH (pal_pkg::WORD_WIDTH),
      .DEPTH (pal_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_more_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_more_ff   <= rd_more_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      if (ctl.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= pal_pkg::POS_W'(found_ff);
         rsp_length_ff <= pal_pkg::POS_W'(count_ff);
      end
   end

   assign stat.cmd      = cmd_ff;
   assign stat.full     = full;
   assign stat.empty    = empty;
   assign stat.ins_ok   = ins_ok;
   assign stat.mod_ok   = mod_ok;
   assign stat.busy     = rd_more_ff || pend_ff;
   assign stat.hit      = hit;
   assign stat.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_length         = rsp_length_ff;

   `ASSERT_CLK(a_rsp_no_overwrite, clock, reset, ctl.load_rsp |-> (!rsp_valid_ff || rsp_tready), "response overwritten while still held")
   `ASSERT_CLK(a_ports_apart, clock, reset, (wr_en && rd_en) |-> (wr_addr != rd_ptr_ff), "shift reads and writes the same entry")
   `ASSERT_CLK(a_hit_records, clock, reset, (ctl.step_find && hit) |=> (found_ff != '0), "match did not record a position")

endmodule

### hw/rtl/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl
// Command sequencer: accepts an item, routes it to a walk where it needs one, hands off a result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pal_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  pal_pkg::stat_type stat,
   output pal_pkg::ctrl_type ctl
);

   pal_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pal_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = pal_pkg::S_DECODE;
            end
         end
         pal_pkg::S_DECODE: begin
            case (stat.cmd)
               pal_pkg::CMD_PUSH_BACK, pal_pkg::CMD_PUSH_FRONT: begin
                  state_in = stat.full ? pal_pkg::S_FINISH : pal_pkg::S_SHIFT_UP;
               end
               pal_pkg::CMD_INSERT: begin
                  state_in = (stat.full || !stat.ins_ok) ? pal_pkg::S_FINISH
                                                         : pal_pkg::S_SHIFT_UP;
               end
               pal_pkg::CMD_POP_FRONT: begin
                  state_in = stat.empty ? pal_pkg::S_FINISH : pal_pkg::S_SHIFT_DOWN;
               end
               pal_pkg::CMD_FIND: begin
                  state_in = pal_pkg::S_SEARCH;
               end
               default: begin
                  state_in = pal_pkg::S_FINISH;
               end
            endcase
         end
         pal_pkg::S_SHIFT_UP: begin
            if (!stat.busy) begin
               state_in = pal_pkg::S_FINISH;
            end
         end
         pal_pkg::S_SHIFT_DOWN: begin
            if (!stat.busy) begin
               state_in = pal_pkg::S_FINISH;
            end
         end
         pal_pkg::S_SEARCH: begin
            if (stat.hit || !stat.busy) begin
               state_in = pal_pkg::S_FINISH;
            end
         end
         pal_pkg::S_FINISH: begin
            if (stat.rsp_free) begin
               state_in = pal_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pal_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl        = '0;
      req_tready = 1'b0;
      case (state_ff)
         pal_pkg::S_IDLE: begin
            req_tready = 1'b1;
            ctl.accept = req_tvalid;
         end
         pal_pkg::S_DECODE: begin
            ctl.decode = 1'b1;
            case (stat.cmd)
               pal_pkg::CMD_PUSH_BACK, pal_pkg::CMD_PUSH_FRONT: begin
                  ctl.setup_up = !stat.full;
               end
               pal_pkg::CMD_INSERT: begin
                  ctl.setup_up = !stat.full && stat.ins_ok;
               end
               pal_pkg::CMD_POP_FRONT: begin
                  ctl.setup_down = !stat.empty;
               end
               pal_pkg::CMD_MODIFY: begin
                  ctl.write_modify = stat.mod_ok;
               end
               pal_pkg::CMD_FIND: begin
                  ctl.setup_find = 1'b1;
               end
               default: begin
                  ctl.decode = 1'b1;
               end
            endcase
         end
         pal_pkg::S_SHIFT_UP: begin
            // Once the shift has drained, the new word goes into its slot.
            ctl.step_up    = stat.busy;
            ctl.write_word = !stat.busy;
         end
         pal_pkg::S_SHIFT_DOWN: begin
            ctl.step_down = stat.busy;
         end
         pal_pkg::S_SEARCH: begin
            ctl.step_find = 1'b1;
         end
         pal_pkg::S_FINISH: begin
            ctl.load_rsp = stat.rsp_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pal_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_CLK(a_accept_decodes, clock, reset, ctl.accept |=> (state_ff == pal_pkg::S_DECODE), "accepted item not decoded")
   `ASSERT_CLK(a_one_write, clock, reset, $onehot0({ctl.step_up, ctl.step_down, ctl.write_word, ctl.write_modify}), "two RAM writers at once")

endmodule

### hw/rtl/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed words in an entry RAM with a length register.
// ----------------------------------------------------------------------------
// The block keeps an ordered list of up to DEPTH words and runs one command
// per item: push back, push front, pop back, pop front, insert at a 1-based
// position, modify at a position, find the first match, and clear. Every item
// gives exactly one result item carrying a status, the found position (zero
// unless a find matched) and the length after the command. Items are handled
// one at a time. Pop back, modify, clear and rejected commands go from the
// decode state straight to the result. Push back, push front and insert
// shift the later entries up one slot and then write the new word, pop
// front shifts the kept entries down to slot zero, and find walks from the
// first entry until a match or the end of the list. The longest item is a
// find without a match in a full list. The walks move one entry per cycle
// through the single read port and single write port of the entry RAM. A
// finished result waits in an output register, and a new item is taken
// while it waits. Slots beyond the current length are never read, so clear
// and the pops never zero any slot and no clearing pass is needed after
// reset.
module positional_array_list (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // value [31:0], position [42:32], zero fill above.
   input  logic [pal_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command [2:0].
   input  logic [pal_pkg::CMD_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status [2:0], found_position [13:3], length [24:14], zero fill above.
   output logic [pal_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   pal_pkg::ctrl_type             ctl;
   pal_pkg::stat_type             stat;
   pal_pkg::status_type           rsp_status;
   logic [pal_pkg::POS_W-1:0]     rsp_found_position;
   logic [pal_pkg::POS_W-1:0]     rsp_length;

   // The controller only sequences; every stored value lives in the datapath.
   pal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   pal_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .stat               (stat),
      .req_command        (req_tuser),
      .req_value          (req_tdata[pal_pkg::VALUE_W-1:0]),
      .req_position       (req_tdata[pal_pkg::VALUE_W +: pal_pkg::POS_W]),
      .rsp_tready         (rsp_tready),
      .rsp_valid          (rsp_tvalid),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_length         (rsp_length)
   );

   // Result fields are packed from the lowest bit up and zero filled.
   assign rsp_tdata = pal_pkg::RSP_DATA_W'({rsp_length, rsp_found_position, rsp_status});

endmodule

### tb/sv/tb_positional_array_list.sv
// ----------------------------------------------------------------------------
// tb_positional_array_list
// Self-checking testbench for the positional array list.
// ----------------------------------------------------------------------------
// Commands go in on the request stream. An in-bench copy of the list predicts
// the status, the found position and the length of every result item, and
// each result is checked field by field against the oldest prediction. The
// run has three parts. A short directed part covers the empty list, the field
// extremes and every command. A fill part grows the list to its full depth to
// reach the full status and the longest shifts and searches. A random part
// keeps the list short and mixes all commands. Both streams idle at random.
// ----------------------------------------------------------------------------
module tb_positional_array_list;
   timeunit 1ns;
   timeprecision 1ps;

   import pal_pkg::*;

   localparam int RANDOM_ITEMS = 580;
   // Drain wait that covers the short commands once nothing is expected any more.
   localparam int DRAIN_CYCLES = 32;
   localparam int SHOWN_ERRORS = 50;

   // Expected contents of one result item.
   typedef struct {
      status_type       status;
      logic [POS_W-1:0] found_pos;
      logic [POS_W-1:0] length;
   } list_result_type;

   // The scoreboard holds its own copy of the list. Each accepted command is
   // applied to the copy at once, and the outcome waits in order until the
   // matching result item comes out of the block.
   class list_scoreboard;
      logic [WORD_WIDTH-1:0] words [DEPTH];
      int                    count;
      list_result_type       pending [$];
      int                    errors;
      int                    checked;

      function new();
         wipe();
         errors  = 0;
         checked = 0;
      endfunction

      function void wipe();
         foreach (words[i]) words[i] = '0;
         count = 0;
      endfunction

      // Opens a gap at the slot by moving the later entries up by one.
      function void place(int slot, logic [WORD_WIDTH-1:0] w);
         for (int i = count; i > slot; i--) words[i] = words[i-1];
         words[slot] = w;
         count++;
      endfunction

      // Number of entries a pop removes. A negative count removes nothing and
      // a count above the length removes everything and saturates.
      function int drop_count(logic [VALUE_W-1:0] value, output status_type st);
         st = ST_OK;
         if (value[VALUE_W-1]) return 0;
         if (value > count) begin
            st = ST_SATURATED;
            return count;
         end
         return int'(value);
      endfunction

      function void note_item(cmd_type cmd, logic [VALUE_W-1:0] value,
                              logic [POS_W-1:0] pos);
         list_result_type       r;
         logic [WORD_WIDTH-1:0] w;
         int                    n;
         int                    i;
         w           = WORD_WIDTH'($signed(value));
         r.status    = ST_OK;
         r.found_pos = '0;
         case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
               if (count >= DEPTH) r.status = ST_FULL;
               else place((cmd == CMD_PUSH_BACK) ? count : 0, w);
            end
            CMD_POP_BACK: begin
               if (count == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  n = drop_count(value, r.status);
                  repeat (n) begin
                     count--;
                     words[count] = '0;
                  end
               end
            end
            CMD_POP_FRONT: begin
               if (count == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  n = drop_count(value, r.status);
                  for (i = 0; i + n < count; i++) words[i] = words[i+n];
                  for (; i < count; i++) words[i] = '0;
                  count -= n;
               end
            end
            CMD_INSERT: begin
               if (count >= DEPTH) r.status = ST_FULL;
               else if (pos == 0 || int'(pos) > count + 1) r.status = ST_BAD_POS;
               else place(int'(pos) - 1, w);
            end
            CMD_MODIFY: begin
               if (pos == 0 || int'(pos) > count) r.status = ST_BAD_POS;
               else words[int'(pos) - 1] = w;
            end
            CMD_FIND: begin
               r.status = ST_NOT_FOUND;
               for (i = 0; i < count; i++) begin
                  if (words[i] == w) begin
                     r.found_pos = POS_W'(i + 1);
                     r.status    = ST_OK;
                     break;
                  end
               end
            end
            CMD_CLEAR: wipe();
            default: ;
         endcase
         r.length = POS_W'(count);
         pending.push_back(r);
      endfunction

      // Prints one line per mismatch, up to a limit, and counts every one.
      task report_mismatch(string what);
         errors++;
         if (errors <= SHOWN_ERRORS) $display("%0t MISMATCH %s", $time, what);
      endtask

      task check_result(logic [RSP_DATA_W-1:0] data);
         list_result_type  want;
         logic [2:0]       got_status;
         logic [POS_W-1:0] got_found;
         logic [POS_W-1:0] got_length;
         got_status = data[STATUS_W-1:0];
         got_found  = data[STATUS_W +: POS_W];
         got_length = data[STATUS_W+POS_W +: POS_W];
         checked++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("result %0d came with none expected", checked));
            return;
         end
         want = pending.pop_front();
         if (got_status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      checked, got_status, want.status));
         if (got_found !== want.found_pos)
            report_mismatch($sformatf("result %0d found position %0d, expected %0d",
                                      checked, got_found, want.found_pos));
         if (got_length !== want.length)
            report_mismatch($sformatf("result %0d length %0d, expected %0d",
                                      checked, got_length, want.length));
      endtask
   endclass

   // Every input has a known value from time zero.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   list_scoreboard sb = new();

   // Sender pacing: items go out in bursts, and some bursts start with no
   // gap so that long stretches without idling also occur.
   int burst_left = 0;

   // Receiver pacing: the stall pattern changes at regular intervals
   // between always ready, half ready and mostly stalled.
   int rx_mode  = 0;
   int rx_cycle = 0;

   positional_array_list uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Draws a word: often a small value so that finds hit and duplicates
   // appear, sometimes an extreme, otherwise anything.
   function automatic logic [VALUE_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return VALUE_W'(int'($urandom_range(0, 6)) - 3);
      if (roll < 6) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom;
   endfunction

   // Presents one item and returns at the edge where the block takes it.
   // The valid line drops only at the start of an idle gap, so it never gets
   // two assignments in one time step.
   task automatic send_item(input cmd_type cmd, input logic [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({pos, value});
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_item(cmd, value, pos);
   endtask

   // Result side: check what was taken at this edge, then set up the ready
   // line for the next one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   initial begin
      cmd_type          cmd;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0] pos;
      int               roll;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The empty list comes first: pops, find and modify
      // have nothing to work on and out-of-range inserts are refused.
      send_item(CMD_POP_BACK,  32'd1, 11'd0);
      send_item(CMD_POP_FRONT, 32'd1, 11'd0);
      send_item(CMD_FIND,      32'd0, 11'd0);
      send_item(CMD_MODIFY,    32'd7, 11'd1);
      send_item(CMD_INSERT,    32'd7, 11'd0);
      send_item(CMD_INSERT,    32'd7, 11'd2);
      // Build a short list from the word extremes. Inserting at length + 1
      // appends, and a duplicate lets find show that the first match wins.
      send_item(CMD_INSERT,     32'h8000_0000, 11'd1);
      send_item(CMD_PUSH_BACK,  32'h7FFF_FFFF, 11'h7FF);
      send_item(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 11'd0);
      send_item(CMD_INSERT,     32'd5,         11'd4);
      send_item(CMD_INSERT,     32'd5,         11'd2);
      send_item(CMD_FIND,       32'd5,         11'd0);
      send_item(CMD_FIND,       32'h8000_0000, 11'd0);
      // Modify accepts positions up to the length and nothing beyond.
      send_item(CMD_MODIFY,     32'd0,         11'd5);
      send_item(CMD_MODIFY,     32'd9,         11'd6);
      send_item(CMD_MODIFY,     32'd9,         11'h7FF);
      send_item(CMD_INSERT,     32'd9,         11'd1024);
      // A negative pop count and a zero count remove nothing. Counts above
      // the length empty the list and saturate.
      send_item(CMD_POP_BACK,   32'h8000_0000, 11'd0);
      send_item(CMD_POP_FRONT,  32'd2,         11'd0);
      send_item(CMD_POP_BACK,   32'd0,         11'd0);
      send_item(CMD_POP_FRONT,  32'h7FFF_FFFF, 11'd0);
      send_item(CMD_PUSH_BACK,  32'd1,         11'd0);
      send_item(CMD_PUSH_BACK,  32'd2,         11'd0);
      send_item(CMD_POP_BACK,   32'd5,         11'd0);
      send_item(CMD_CLEAR,      32'hFFFF_FFFF, 11'h7FF);

      // Fill the list to its full depth with cheap appends.
      while (sb.count < DEPTH) send_item(CMD_PUSH_BACK, pick_word(), POS_W'($urandom));
      // Every kind of insert is refused on a full list, while modify and
      // find still work and the longest shifts run in both directions.
      send_item(CMD_PUSH_BACK,  pick_word(), 11'd0);
      send_item(CMD_PUSH_FRONT, pick_word(), 11'd0);
      send_item(CMD_INSERT,     pick_word(), 11'd1);
      send_item(CMD_INSERT,     pick_word(), 11'd1025);
      send_item(CMD_MODIFY,     32'h1234_5678, 11'd1024);
      send_item(CMD_MODIFY,     pick_word(), 11'd1025);
      send_item(CMD_FIND,       32'h1234_5678, 11'd0);
      send_item(CMD_FIND,       $urandom,    11'd0);
      send_item(CMD_POP_FRONT,  32'd1,       11'd0);
      send_item(CMD_PUSH_FRONT, pick_word(), 11'd0);
      send_item(CMD_POP_BACK,   32'd1,       11'd0);
      send_item(CMD_INSERT,     pick_word(), 11'd1);
      send_item(CMD_POP_FRONT,  32'd1025,    11'd0);

      // Random part. The list stays short so that the walks stay cheap;
      // once it grows past a few dozen entries, pops are favored.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         roll = $urandom_range(0, 99);
         if (sb.count > 40 && roll < 30)
            cmd = (roll < 15) ? CMD_POP_BACK : CMD_POP_FRONT;
         else
            cmd = cmd_type'($urandom_range(0, 7));
         // Clearing too often would keep the list nearly empty.
         if (cmd == CMD_CLEAR && $urandom_range(0, 3) != 0) cmd = CMD_FIND;
         value = pick_word();
         pos   = POS_W'($urandom);
         case (cmd)
            CMD_POP_BACK, CMD_POP_FRONT: begin
               roll = $urandom_range(0, 99);
               if (roll < 60)      value = $urandom_range(0, 3);
               else if (roll < 75) value = VALUE_W'(sb.count + $urandom_range(0, 3));
               else if (roll < 85) value = {1'b1, 31'($urandom)};
               else                value = $urandom;
            end
            CMD_INSERT, CMD_MODIFY: begin
               roll = $urandom_range(0, 99);
               if (roll < 70)      pos = POS_W'($urandom_range(1, sb.count + 1));
               else if (roll < 78) pos = '0;
               else if (roll < 85) pos = POS_W'(sb.count + $urandom_range(1, 2));
            end
            CMD_FIND: begin
               if (sb.count > 0 && $urandom_range(0, 9) < 6)
                  value = sb.words[$urandom_range(0, sb.count - 1)];
            end
            default: ;
         endcase
         send_item(cmd, value, pos);
      end
      req_tvalid <= 1'b0;

      // Wait for every outstanding result, then a little longer so that a
      // stray extra result would still be caught.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Guard against a hang. The slowest correct run, with every item walking
   // the whole list and both sides stalling, stays well below this.
   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end

endmodule
